### rtl/core/gcd_pkg.sv
// Shared constants, codes and types of the graph cycle detector.
`timescale 1ns / 1ps
package gcd_pkg;

	// Node count by default and fixed width of the node fields
	localparam int GCD_NODES_DEF = 64;
	localparam int NODE_FIELD_W  = 6;

	// Action codes of an input item
	localparam logic [1:0] ACT_ADD   = 2'd0;
	localparam logic [1:0] ACT_CHECK = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0]              action;
		logic [NODE_FIELD_W-1:0] node_u;
		logic [NODE_FIELD_W-1:0] node_v;
		logic                    one_way;
	} gcd_in_t;

	typedef struct packed {
		logic cycle_found;
		logic root_was_visited;
		logic any_cycle;
	} gcd_out_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_CLEAR,
		ST_IDLE,
		ST_ADD_U,
		ST_ADD_V,
		ST_SCAN,
		ST_POP,
		ST_DONE
	} gcd_state_t;

endpackage

### rtl/core/gcd_chan_if.sv
// Valid/ready channel that carries one item of type T.
`timescale 1ns / 1ps
interface gcd_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### rtl/core/gcd_ffs.sv
// Find the lowest set bit of a vector.
`timescale 1ns / 1ps
module gcd_ffs #(
	parameter int WIDTH = gcd_pkg::GCD_NODES_DEF
) (
	input  logic [WIDTH-1:0]         vec,
	output logic                     hit,
	output logic [$clog2(WIDTH)-1:0] idx
);
	import gcd_pkg::*;

	// Scan from the top so the lowest set bit wins
	always_comb begin
		hit = 1'b0;
		idx = '0;
		for (int i = WIDTH - 1; i >= 0; i--) begin
			if (vec[i]) begin
				hit = 1'b1;
				idx = ($clog2(WIDTH))'(i);
			end
		end
	end
endmodule

### rtl/core/graph_cycle_detect_dfs_unit.sv
// Top level of the depth-first cycle detector over an adjacency bit matrix.
`timescale 1ns / 1ps
// Each item adds an edge, runs a depth-first cycle check from a root, or clears the
// graph, and gives exactly one result item. The block works on one item at a time; the
// adjacency matrix sits in a memory of NODES rows with one read port, and that port
// sets the pace: an add reads the row of u and writes it back, and when stored both ways
// it then reads and writes the row of v; a check reads the row of every node that the
// walk reaches and reads a row again for every backtrack to a frame below the top, and
// ends at once when its root was already visited; a clear sweeps all NODES rows. After
// reset the same sweep of all NODES rows runs before the first item is taken. A result
// register lets the next item enter while the previous result still waits.
module graph_cycle_detect_dfs_unit #(
	parameter int NODES = gcd_pkg::GCD_NODES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	gcd_chan_if.sink    in_ch,
	gcd_chan_if.source  out_ch
);
	import gcd_pkg::*;

	localparam int NODE_W  = $clog2(NODES);
	localparam int SCAN_W  = NODE_W + 1;
	localparam int DEPTH_W = NODE_W + 1;
	localparam int WIDE_W  = (NODE_W > NODE_FIELD_W ? NODE_W : NODE_FIELD_W) + 1;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [NODE_W-1:0] parent;
		logic              has_parent;
		logic [SCAN_W-1:0] scan;
	} frame_t;

	// Memories
	logic [NODES-1:0] adj_mem [NODES];
	frame_t           stk_mem [NODES];

	gcd_state_t        state_q, state_d;
	logic [NODE_W-1:0] cnt_q;
	logic [1:0]        act_q;
	logic [NODE_W-1:0] u_q, v_q;
	logic              one_way_q;
	frame_t            top_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [NODES-1:0]  visited_q;
	logic              sticky_q;
	logic              found_q, skip_q;
	logic [NODES-1:0]  adj_rd_q;
	frame_t            stk_rd_q;
	logic              out_valid_q;
	gcd_out_t          out_data_q;

	// Memory port controls
	logic              adj_we, adj_re;
	logic [NODE_W-1:0] adj_wa, adj_ra;
	logic [NODES-1:0]  adj_wd;
	logic              stk_we, stk_re;
	logic [NODE_W-1:0] stk_wa, stk_ra;
	frame_t            stk_wd;

	logic              accept;
	logic [WIDE_W-1:0] u_ext, v_ext;
	logic              u_ok, v_ok;
	logic [NODE_W-1:0] u_idx, v_idx;
	logic [NODES-1:0]  scan_mask, cand;
	logic              hit;
	logic [NODE_W-1:0] hit_idx;
	logic              is_parent, hit_visited;
	logic              push_c, pop_c, cyc_c, last_pop, out_load;
	logic [DEPTH_W-1:0] depth_dec;

	// Decode the input item
	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign u_ext       = WIDE_W'(in_ch.data.node_u);
	assign v_ext       = WIDE_W'(in_ch.data.node_v);
	assign u_ok        = u_ext < WIDE_W'(NODES);
	assign v_ok        = v_ext < WIDE_W'(NODES);
	assign u_idx       = u_ext[NODE_W-1:0];
	assign v_idx       = v_ext[NODE_W-1:0];

	// Pick the next neighbor at or above the scan position
	always_comb begin
		for (int i = 0; i < NODES; i++) begin
			scan_mask[i] = SCAN_W'(i) >= top_q.scan;
		end
	end
	assign cand = adj_rd_q & scan_mask;

	gcd_ffs #(.WIDTH(NODES)) u_ffs (
		.vec (cand),
		.hit (hit),
		.idx (hit_idx)
	);

	assign is_parent   = top_q.has_parent && (hit_idx == top_q.parent);
	assign hit_visited = visited_q[hit_idx];
	assign pop_c       = (state_q == ST_SCAN) && !hit;
	assign push_c      = (state_q == ST_SCAN) && hit && !is_parent && !hit_visited;
	assign cyc_c       = (state_q == ST_SCAN) && hit && !is_parent && hit_visited;
	assign last_pop    = depth_q == DEPTH_W'(1);
	assign depth_dec   = depth_q - DEPTH_W'(1);
	assign out_load    = (state_q == ST_DONE) && (!out_valid_q || out_ch.ready);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (cnt_q == NODE_W'(NODES - 1)) state_d = ST_IDLE;
			end
			ST_CLEAR: begin
				if (cnt_q == NODE_W'(NODES - 1)) state_d = ST_DONE;
			end
			ST_IDLE: begin
				if (accept) begin
					case (in_ch.data.action)
						ACT_ADD: state_d = (u_ok && v_ok) ? ST_ADD_U : ST_DONE;
						ACT_CHECK: begin
							state_d = (u_ok && !visited_q[u_idx]) ? ST_SCAN : ST_DONE;
						end
						ACT_CLEAR: state_d = ST_CLEAR;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_ADD_U: state_d = one_way_q ? ST_DONE : ST_ADD_V;
			ST_ADD_V: state_d = ST_DONE;
			ST_SCAN: begin
				if (cyc_c) begin
					state_d = ST_DONE;
				end else if (pop_c) begin
					state_d = last_pop ? ST_DONE : ST_POP;
				end
			end
			ST_POP: state_d = ST_SCAN;
			ST_DONE: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory port controls
	always_comb begin
		adj_we = 1'b0;
		adj_wa = cnt_q;
		adj_wd = '0;
		adj_re = 1'b0;
		adj_ra = u_idx;
		stk_we = 1'b0;
		stk_wa = depth_dec[NODE_W-1:0];
		stk_wd = top_q;
		stk_re = 1'b0;
		stk_ra = depth_dec[NODE_W-1:0] - NODE_W'(1);
		case (state_q)
			ST_INIT, ST_CLEAR: begin
				adj_we = 1'b1;
			end
			ST_IDLE: begin
				adj_re = accept && u_ok;
			end
			ST_ADD_U: begin
				adj_we = 1'b1;
				adj_wa = u_q;
				adj_wd = adj_rd_q | (NODES'(1) << v_q);
				adj_re = !one_way_q;
				adj_ra = v_q;
			end
			ST_ADD_V: begin
				adj_we = 1'b1;
				adj_wa = v_q;
				adj_wd = adj_rd_q | (NODES'(1) << u_q);
			end
			ST_SCAN: begin
				// Park the top frame and fetch the row of the new node
				stk_we      = push_c;
				stk_wd.scan = SCAN_W'(hit_idx) + SCAN_W'(1);
				adj_re      = push_c;
				adj_ra      = hit_idx;
				stk_re      = pop_c && !last_pop;
			end
			ST_POP: begin
				adj_re = 1'b1;
				adj_ra = stk_rd_q.node;
			end
			default: ;
		endcase
	end

	// Adjacency memory
	always_ff @(posedge clk) begin
		if (adj_we) adj_mem[adj_wa] <= adj_wd;
		if (adj_re) adj_rd_q <= adj_mem[adj_ra];
	end

	// Stack memory
	always_ff @(posedge clk) begin
		if (stk_we) stk_mem[stk_wa] <= stk_wd;
		if (stk_re) stk_rd_q <= stk_mem[stk_ra];
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			depth_q     <= '0;
			visited_q   <= '0;
			sticky_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INIT || state_q == ST_CLEAR) cnt_q <= cnt_q + NODE_W'(1);
			if (accept) begin
				cnt_q <= '0;
				if (in_ch.data.action == ACT_CLEAR) begin
					visited_q <= '0;
					sticky_q  <= 1'b0;
				end else if (in_ch.data.action == ACT_CHECK && u_ok && !visited_q[u_idx]) begin
					visited_q[u_idx] <= 1'b1;
					depth_q          <= DEPTH_W'(1);
				end
			end
			if (push_c) begin
				visited_q[hit_idx] <= 1'b1;
				depth_q            <= depth_q + DEPTH_W'(1);
			end
			if (pop_c) depth_q <= depth_dec;
			if (cyc_c) begin
				sticky_q <= 1'b1;
				depth_q  <= '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item fields, walk frame and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q     <= in_ch.data.action;
			u_q       <= u_idx;
			v_q       <= v_idx;
			one_way_q <= in_ch.data.one_way;
			found_q   <= 1'b0;
			skip_q    <= (in_ch.data.action == ACT_CHECK) && u_ok && visited_q[u_idx];
			top_q     <= '{node: u_idx, parent: '0, has_parent: 1'b0, scan: '0};
		end
		if (push_c) begin
			top_q <= '{node: hit_idx, parent: top_q.node, has_parent: 1'b1, scan: '0};
		end else if (state_q == ST_SCAN && hit) begin
			top_q.scan <= SCAN_W'(hit_idx) + SCAN_W'(1);
		end
		if (cyc_c) found_q <= 1'b1;
		if (state_q == ST_POP) top_q <= stk_rd_q;
		if (out_load) begin
			out_data_q.cycle_found      <= found_q;
			out_data_q.root_was_visited <= skip_q;
			out_data_q.any_cycle        <= sticky_q;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_data_q;

	// A pushed node is marked visited right after
	a_push_marks: assert property (@(posedge clk) disable iff (!arst_n)
		push_c |=> visited_q[$past(hit_idx)])
		else $error("pushed node not marked visited");

	// The walk stack is empty whenever the block waits for an item
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (depth_q == '0))
		else $error("walk stack not empty at idle");

	// A clear result leaves no marks and no sticky cycle
	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && act_q == ACT_CLEAR) |-> (visited_q == '0 && !sticky_q))
		else $error("clear left marks or sticky flag");

	// A found cycle is never reported with a skipped root, and it sets the sticky flag
	a_result_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (!(out_ch.data.cycle_found && out_ch.data.root_was_visited)
			&& (!out_ch.data.cycle_found || out_ch.data.any_cycle)))
		else $error("inconsistent result item");

endmodule
